@@ rtl/core/triangle_count_csr_macros.svh @@
// Assertion macros shared by the triangle counter checker.
`ifndef TRIANGLE_COUNT_CSR_MACROS_SVH
`define TRIANGLE_COUNT_CSR_MACROS_SVH

// Overlapping implication under reset.
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/tcc_pkg.sv @@
// Package with the constants and helpers of the triangle counter.
package tcc_pkg;
    localparam int NodeAw  = 10;
    localparam int EntryAw = 13;
    localparam int OffW    = 14;
    localparam int CntW    = 34;
    localparam logic [10:0] MaxNodes   = 11'd1024;
    localparam logic [13:0] MaxEntries = 14'd8192;

    localparam logic [1:0] OP_OFFSET   = 2'd0;
    localparam logic [1:0] OP_NEIGHBOR = 2'd1;
    localparam logic [1:0] OP_COUNT    = 2'd2;

    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_ENTRY_COUNT = 1'b1;

    typedef struct packed {
        logic [OffW-1:0] beg;
        logic [OffW-1:0] fin;
    } bounds_t;

    // Clamp both list bounds to the entry count and make a reversed list empty.
    function automatic bounds_t clamp_bounds(logic [OffW-1:0] b, logic [OffW-1:0] e,
                                             logic [OffW-1:0] m);
        bounds_t r;
        r.beg = (b > m) ? m : b;
        r.fin = (e > m) ? m : e;
        if (r.beg > r.fin)
        begin
            r.beg = r.fin;
        end
        return r;
    endfunction
endpackage

@@ rtl/core/triangle_count_csr.sv @@
// Triangle counter over a graph in compressed sparse row form.
// Usage: an item is taken at a rising edge with start high and busy low.
// Operation offset writes the list start of node index, neighbor writes the
// neighbour id at entry index; both finish in the cycle they are taken, give
// no result and leave busy low, so loads stream at one per cycle.
// Operation count raises busy and walks every node u and each neighbour v
// below u, merging the two sorted lists in the neighbour memory with both
// of its read ports. Each node's offsets are read; for each neighbour below
// u the entry, then v's offsets are read; each merge step is a memory read,
// then a compare. A node's walk stops at an entry not below u or its list end.
// The count is kept as a quotient and remainder by three, stepped on every
// match, so no division follows the walk. The result is shown for one cycle
// with done high as busy falls; the receiver cannot stall it.
// Registers are written on the cfg channel (cfg_ready is always high);
// index 0 is node_count, index 1 is entry_count; the user writes them only
// when idle, which the block does not enforce. Reset clears the registers
// and control state; tables are undefined until loaded, need no clearing.
module triangle_count_csr (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [12:0] index,
    input  logic [13:0] value,
    output logic        done,
    output logic [31:0] triangles,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);
    import tcc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UCHECK = 4'd1;
    localparam logic [3:0] S_UWAIT  = 4'd2;
    localparam logic [3:0] S_IREAD  = 4'd3;
    localparam logic [3:0] S_IWAIT  = 4'd4;
    localparam logic [3:0] S_VWAIT  = 4'd5;
    localparam logic [3:0] S_MREAD  = 4'd6;
    localparam logic [3:0] S_MCMP   = 4'd7;

    logic [OffW-1:0] off_mem [0:(1<<NodeAw)-1];
    logic [OffW-1:0] nb_mem  [0:(1<<EntryAw)-1];

    logic [3:0]        state_reg, state_next;
    logic [10:0]       ncfg_reg;
    logic [13:0]       mcfg_reg;
    logic [10:0]       n_reg, n_next;
    logic [OffW-1:0]   m_reg, m_next;
    logic [10:0]       u_reg, u_next;
    logic [NodeAw-1:0] v_reg, v_next;
    logic              vlast_reg, vlast_next;
    logic [OffW-1:0]   ub_reg, ub_next, ue_reg, ue_next, i_reg, i_next;
    logic [OffW-1:0]   p0_reg, p0_next, p1_reg, p1_next;
    logic [OffW-1:0]   p2_reg, p2_next, p3_reg, p3_next;
    logic [OffW-1:0]   hits_reg, hits_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic [CntW-1:0]   q_reg, q_next;
    logic [1:0]        rem_reg, rem_next;
    logic              done_reg, done_next;
    logic [31:0]       tri_reg, tri_next;
    logic              ovf_reg, ovf_next;

    logic              off_re;
    logic [NodeAw-1:0] off_ra0, off_ra1;
    logic [OffW-1:0]   off_rd0, off_rd1;
    logic              nb_re;
    logic [EntryAw-1:0] nb_ra0, nb_ra1;
    logic [OffW-1:0]   nb_rd0, nb_rd1;

    logic              accept;
    logic [CntW:0]     sum;
    bounds_t           bnd;
    logic [10:0]       u_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign triangles = tri_reg;
    assign overflow  = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_OFFSET && index[12:NodeAw] == '0)
        begin
            off_mem[index[NodeAw-1:0]] <= value;
        end
        if (off_re)
        begin
            off_rd0 <= off_mem[off_ra0];
            off_rd1 <= off_mem[off_ra1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_NEIGHBOR)
        begin
            nb_mem[index] <= value;
        end
        if (nb_re)
        begin
            nb_rd0 <= nb_mem[nb_ra0];
            nb_rd1 <= nb_mem[nb_ra1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncfg_reg <= '0;
            mcfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT:  ncfg_reg <= cfg_data[10:0];
                CFG_ENTRY_COUNT: mcfg_reg <= cfg_data;
                default:         ncfg_reg <= ncfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;  m_next = m_reg;  u_next = u_reg;
        v_next = v_reg;  vlast_next = vlast_reg;
        ub_next = ub_reg;  ue_next = ue_reg;  i_next = i_reg;
        p0_next = p0_reg;  p1_next = p1_reg;  p2_next = p2_reg;  p3_next = p3_reg;
        hits_next = hits_reg;  cnt_next = cnt_reg;  sat_next = sat_reg;
        q_next = q_reg;  rem_next = rem_reg;
        done_next = 1'b0;  tri_next = tri_reg;  ovf_next = ovf_reg;
        u_inc = u_reg + 11'd1;
        off_re = 1'b0;  off_ra0 = u_reg[NodeAw-1:0];  off_ra1 = u_inc[NodeAw-1:0];
        nb_re = 1'b0;  nb_ra0 = i_reg[EntryAw-1:0];  nb_ra1 = p2_reg[EntryAw-1:0];
        sum   = {1'b0, cnt_reg} + {{(CntW+1-OffW){1'b0}}, hits_reg};
        bnd   = clamp_bounds(off_rd0, off_rd1, m_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_COUNT)
                begin
                    n_next   = (ncfg_reg > MaxNodes) ? MaxNodes : ncfg_reg;
                    m_next   = (mcfg_reg > MaxEntries) ? MaxEntries : mcfg_reg;
                    u_next   = '0;
                    cnt_next = '0;
                    sat_next = 1'b0;
                    q_next   = '0;
                    rem_next = '0;
                    state_next = S_UCHECK;
                end
            end
            S_UCHECK:
            begin
                if (u_reg == n_reg)
                begin
                    done_next = 1'b1;
                    if (sat_reg || q_reg[CntW-1:32] != '0)
                    begin
                        tri_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        tri_next = q_reg[31:0];
                        ovf_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    off_re = 1'b1;
                    state_next = S_UWAIT;
                end
            end
            S_UWAIT:
            begin
                bnd = clamp_bounds(off_rd0, (u_inc == n_reg) ? m_reg : off_rd1, m_reg);
                ub_next = bnd.beg;
                ue_next = bnd.fin;
                i_next  = bnd.beg;
                state_next = S_IREAD;
            end
            S_IREAD:
            begin
                if (i_reg >= ue_reg)
                begin
                    u_next = u_inc;
                    state_next = S_UCHECK;
                end
                else
                begin
                    nb_re = 1'b1;
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT:
            begin
                if (nb_rd0 >= {3'b000, u_reg})
                begin
                    u_next = u_inc;
                    state_next = S_UCHECK;
                end
                else
                begin
                    // The id is below u, so it fits the node address width.
                    v_next = nb_rd0[NodeAw-1:0];
                    off_re = 1'b1;
                    off_ra0 = nb_rd0[NodeAw-1:0];
                    off_ra1 = nb_rd0[NodeAw-1:0] + 1'b1;
                    vlast_next = ((nb_rd0[10:0] + 11'd1) == n_reg);
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT:
            begin
                bnd = clamp_bounds(off_rd0, vlast_reg ? m_reg : off_rd1, m_reg);
                p0_next = ub_reg;
                p1_next = ue_reg;
                p2_next = bnd.beg;
                p3_next = bnd.fin;
                hits_next = '0;
                state_next = S_MREAD;
            end
            S_MREAD:
            begin
                if (p0_reg < p1_reg && p2_reg < p3_reg)
                begin
                    nb_re = 1'b1;
                    nb_ra0 = p0_reg[EntryAw-1:0];
                    nb_ra1 = p2_reg[EntryAw-1:0];
                    state_next = S_MCMP;
                end
                else
                begin
                    if (sum > {1'b0, {CntW{1'b1}}})
                    begin
                        cnt_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = sum[CntW-1:0];
                    end
                    i_next = i_reg + 1'b1;
                    state_next = S_IREAD;
                end
            end
            S_MCMP:
            begin
                if (nb_rd0 == nb_rd1)
                begin
                    hits_next = hits_reg + 1'b1;
                    // Every third match adds one to the quotient.
                    if (rem_reg == 2'd2)
                    begin
                        rem_next = 2'd0;
                        q_next = q_reg + 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_reg + 1'b1;
                    end
                end
                if (nb_rd0 <= nb_rd1)
                begin
                    p0_next = p0_reg + 1'b1;
                end
                if (nb_rd1 <= nb_rd0)
                begin
                    p2_next = p2_reg + 1'b1;
                end
                state_next = S_MREAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            sat_reg   <= sat_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;  m_reg <= m_next;  u_reg <= u_next;
        v_reg <= v_next;  vlast_reg <= vlast_next;
        ub_reg <= ub_next;  ue_reg <= ue_next;  i_reg <= i_next;
        p0_reg <= p0_next;  p1_reg <= p1_next;  p2_reg <= p2_next;  p3_reg <= p3_next;
        hits_reg <= hits_next;  q_reg <= q_next;  rem_reg <= rem_next;
        tri_reg <= tri_next;  ovf_reg <= ovf_next;
    end
endmodule

@@ rtl/core/tcc_checker.sv @@
// Port-level checker for the triangle counter, bound to the top level.
`include "triangle_count_csr_macros.svh"

module tcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        done,
    input logic [31:0] triangles,
    input logic        overflow
);
    import tcc_pkg::*;

    `TCC_ASSERT_NOW(a_done_ends_busy, clk, rst_n, done, !busy && $past(busy))
    `TCC_ASSERT_NOW(a_busy_fall_done, clk, rst_n, $fell(busy), done)
    `TCC_ASSERT_NEXT(a_count_busy, clk, rst_n, start && !busy && op == OP_COUNT, busy)
    `TCC_ASSERT_NOW(a_ovf_max, clk, rst_n, done && overflow, triangles == 32'hFFFF_FFFF)
endmodule

bind triangle_count_csr tcc_checker u_tcc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
    .done(done), .triangles(triangles), .overflow(overflow)
);
